// File: rtl/fac_pkg.sv
package fac_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_BITS = 32;

  localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int MUL_W  = COORD_BITS + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int W_SHIFT = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-2:0]        ext_t;
  typedef logic signed [MUL_W-1:0]      mul_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [PIDX_W-1:0]            pidx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } plane_t;

  // one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;   // restart accumulator
    logic last;    // plane distance complete after this step
    logic final_p; // last plane of the box
    logic shift;   // offset term: operand a shifted, no multiply
  } mac_cmd_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic final_p;
  } mac_res_t;

  typedef enum logic [2:0] {
    OP_XC = 3'd0,
    OP_YC = 3'd1,
    OP_ZC = 3'd2,
    OP_XE = 3'd3,
    OP_YE = 3'd4,
    OP_ZE = 3'd5,
    OP_W  = 3'd6
  } op_t;

  function automatic mul_t sext(input coord_t v);
    return mul_t'(v);
  endfunction

  function automatic mul_t abs_mag(input coord_t v);
    mul_t e;
    e = mul_t'(v);
    return e[MUL_W-1] ? -e : e;
  endfunction

  function automatic mul_t zext(input ext_t v);
    return mul_t'({2'b00, v});
  endfunction

endpackage

// File: rtl/fac_if.sv
interface fac_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  logic [2:0]          plane_index;
  fac_pkg::coord_t     plane_x;
  fac_pkg::coord_t     plane_y;
  fac_pkg::coord_t     plane_z;
  fac_pkg::coord_t     plane_w;
  fac_pkg::coord_t     center_x;
  fac_pkg::coord_t     center_y;
  fac_pkg::coord_t     center_z;
  fac_pkg::ext_t       extent_x;
  fac_pkg::ext_t       extent_y;
  fac_pkg::ext_t       extent_z;

  modport source (
    output valid, func, plane_index, plane_x, plane_y, plane_z, plane_w,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, func, plane_index, plane_x, plane_y, plane_z, plane_w,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

interface fac_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// File: rtl/fac_plane_store.sv
module fac_plane_store (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  fac_pkg::pidx_t   waddr,
  input  fac_pkg::plane_t  wdata,
  input  fac_pkg::pidx_t   raddr,
  output fac_pkg::plane_t  rdata
);

  fac_pkg::plane_t planes_r [fac_pkg::NUM_PLANES];

  // planes reset to zero: a zero plane never rejects
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fac_pkg::NUM_PLANES; i++) begin
        planes_r[i] <= '0;
      end
    end else if (we) begin
      planes_r[waddr] <= wdata;
    end
  end

  assign rdata = planes_r[raddr];

endmodule

// File: rtl/fac_mac.sv
module fac_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  fac_pkg::mac_cmd_t  cmd,
  input  fac_pkg::mul_t      a,
  input  fac_pkg::mul_t      b,
  output fac_pkg::mac_res_t  res
);

  fac_pkg::prod_t    prod_r, prod_nxt;
  fac_pkg::mac_cmd_t cmd_r;
  fac_pkg::acc_t     acc_r, acc_nxt;
  fac_pkg::mac_res_t res_r;

  // stage 1: one signed multiply, or the scaled offset term
  always_comb begin
    if (cmd.shift) begin
      prod_nxt = fac_pkg::prod_t'(a) <<< fac_pkg::W_SHIFT;
    end else begin
      prod_nxt = fac_pkg::prod_t'(a) * fac_pkg::prod_t'(b);
    end
  end

  // stage 2: exact accumulate
  always_comb begin
    if (cmd_r.first) begin
      acc_nxt = fac_pkg::acc_t'(prod_r);
    end else begin
      acc_nxt = acc_r + fac_pkg::acc_t'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
      res_r <= '0;
    end else begin
      cmd_r         <= cmd;
      res_r.valid   <= cmd_r.valid & cmd_r.last;
      res_r.neg     <= acc_nxt[fac_pkg::ACC_W-1];
      res_r.final_p <= cmd_r.final_p;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/frustum_aabb_cull_core.sv
// Six-plane view-frustum cull of axis-aligned boxes. A load word (func 0)
// writes one plane (normal x/y/z, offset w, signed Q16.16) into the plane
// store; a load to an index past the last plane is dropped and neither
// kind of load gives a result. A test word (func 1) carries box center and
// half extents and returns one visible flag: 0 when some plane has all
// eight corners strictly behind it, 1 otherwise. Planes reset to zero, so
// every box is visible until planes are loaded. Per plane the test forms
// the largest corner distance n.c + |nx|ex + |ny|ey + |nz|ez + w*2^16
// exactly in a wide accumulator, one term per cycle through a single
// shared 33x33 multiplier. A test word issues seven terms per plane, which
// then pass the multiply and accumulate stages before the result is
// presented. in_ch.ready is high only while idle; the result word is held
// on out_ch until taken.
module frustum_aabb_cull_core (
  input  logic       clk,
  input  logic       rst_n,
  fac_in_if.sink     in_ch,
  fac_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  fac_pkg::pidx_t      plane_r, plane_nxt;
  fac_pkg::op_t        op_r, op_nxt;
  logic                reject_r, reject_nxt;
  logic                visible_r, visible_nxt;

  fac_pkg::coord_t     cx_r, cy_r, cz_r;
  fac_pkg::ext_t       ex_r, ey_r, ez_r;

  logic                in_acc;
  logic                store_we;
  fac_pkg::plane_t     wr_plane;
  fac_pkg::plane_t     rd_plane;
  logic                last_plane;

  fac_pkg::mac_cmd_t   cmd;
  fac_pkg::mul_t       op_a, op_b;
  fac_pkg::mac_res_t   res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;

  // loads past the last plane are ignored
  assign store_we = in_acc && (in_ch.func == fac_pkg::FUNC_LOAD) &&
                    (32'(in_ch.plane_index) < fac_pkg::NUM_PLANES);

  assign wr_plane.x = in_ch.plane_x;
  assign wr_plane.y = in_ch.plane_y;
  assign wr_plane.z = in_ch.plane_z;
  assign wr_plane.w = in_ch.plane_w;

  fac_plane_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (store_we),
    .waddr (in_ch.plane_index[fac_pkg::PIDX_W-1:0]),
    .wdata (wr_plane),
    .raddr (plane_r),
    .rdata (rd_plane)
  );

  assign last_plane = (plane_r == fac_pkg::pidx_t'(fac_pkg::NUM_PLANES - 1));

  // term select for the shared unit
  always_comb begin
    cmd  = '0;
    op_a = '0;
    op_b = '0;
    if (state_r == S_RUN) begin
      cmd.valid   = 1'b1;
      cmd.first   = (op_r == fac_pkg::OP_XC);
      cmd.last    = (op_r == fac_pkg::OP_W);
      cmd.final_p = (op_r == fac_pkg::OP_W) && last_plane;
      unique case (op_r)
        fac_pkg::OP_XC: begin
          op_a = fac_pkg::sext(rd_plane.x);
          op_b = fac_pkg::sext(cx_r);
        end
        fac_pkg::OP_YC: begin
          op_a = fac_pkg::sext(rd_plane.y);
          op_b = fac_pkg::sext(cy_r);
        end
        fac_pkg::OP_ZC: begin
          op_a = fac_pkg::sext(rd_plane.z);
          op_b = fac_pkg::sext(cz_r);
        end
        fac_pkg::OP_XE: begin
          op_a = fac_pkg::abs_mag(rd_plane.x);
          op_b = fac_pkg::zext(ex_r);
        end
        fac_pkg::OP_YE: begin
          op_a = fac_pkg::abs_mag(rd_plane.y);
          op_b = fac_pkg::zext(ey_r);
        end
        fac_pkg::OP_ZE: begin
          op_a = fac_pkg::abs_mag(rd_plane.z);
          op_b = fac_pkg::zext(ez_r);
        end
        fac_pkg::OP_W: begin
          op_a      = fac_pkg::sext(rd_plane.w);
          cmd.shift = 1'b1;
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

  fac_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .a     (op_a),
    .b     (op_b),
    .res   (res)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    plane_nxt   = plane_r;
    op_nxt      = op_r;
    reject_nxt  = reject_r;
    visible_nxt = visible_r;

    // each finished plane distance: negative max corner rejects the box
    if (res.valid) begin
      reject_nxt = reject_r | res.neg;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.func == fac_pkg::FUNC_TEST)) begin
          state_nxt  = S_RUN;
          plane_nxt  = '0;
          op_nxt     = fac_pkg::OP_XC;
          reject_nxt = 1'b0;
        end
      end
      S_RUN: begin
        unique case (op_r)
          fac_pkg::OP_XC: op_nxt = fac_pkg::OP_YC;
          fac_pkg::OP_YC: op_nxt = fac_pkg::OP_ZC;
          fac_pkg::OP_ZC: op_nxt = fac_pkg::OP_XE;
          fac_pkg::OP_XE: op_nxt = fac_pkg::OP_YE;
          fac_pkg::OP_YE: op_nxt = fac_pkg::OP_ZE;
          fac_pkg::OP_ZE: op_nxt = fac_pkg::OP_W;
          default: begin
            op_nxt = fac_pkg::OP_XC;
            if (last_plane) begin
              state_nxt = S_DRAIN;
            end else begin
              plane_nxt = plane_r + 1'b1;
            end
          end
        endcase
      end
      S_DRAIN: begin
        if (res.valid && res.final_p) begin
          state_nxt   = S_OUT;
          visible_nxt = ~(reject_r | res.neg);
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      plane_r  <= '0;
      op_r     <= fac_pkg::OP_XC;
      reject_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      plane_r  <= plane_nxt;
      op_r     <= op_nxt;
      reject_r <= reject_nxt;
    end
  end

  // box operands and result word
  always_ff @(posedge clk) begin
    visible_r <= visible_nxt;
    if (in_acc) begin
      cx_r <= in_ch.center_x;
      cy_r <= in_ch.center_y;
      cz_r <= in_ch.center_z;
      ex_r <= in_ch.extent_x;
      ey_r <= in_ch.extent_y;
      ez_r <= in_ch.extent_z;
    end
  end

  assign out_ch.valid   = (state_r == S_OUT);
  assign out_ch.visible = visible_r;

`ifndef NO_ASSERTIONS
  a_res_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("plane result outside a box test");

  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == fac_pkg::FUNC_TEST) |=> (state_r == S_RUN))
    else $error("test word did not start the sequencer");

  a_reject_hides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && reject_r) |-> !out_ch.visible)
    else $error("rejected box reported visible");

  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (32'(plane_r) < fac_pkg::NUM_PLANES))
    else $error("plane counter out of range");
`endif

endmodule
